// ===== hdl/conv3x3_kernel_select_filter_macros.svh =====
// ----------------------------------------------------------------------------
// conv3x3 kernel select filter: assertion macros
// Shared assertion wrappers, clocked on clock; all compile away with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_KERNEL_SELECT_FILTER_MACROS_SVH
`define CONV3X3_KERNEL_SELECT_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
// checked outside reset only
`define C3F_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("c3f assertion failed");
// checked at every edge, reset included
`define C3F_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("c3f assertion failed");
`else
`define C3F_ASSERT(label, prop)
`define C3F_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== hdl/c3f_pkg.sv =====
// ----------------------------------------------------------------------------
// c3f_pkg
// Types, codes and constants shared by the 3x3 convolution filter.
// ----------------------------------------------------------------------------
package c3f_pkg;

   localparam int PIX_W       = 8;
   localparam int COORD_W     = 10;
   localparam int MODE_W      = 3;
   localparam int FW_W        = 11;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 1;
   localparam int WIN_TAPS    = 9;
   localparam int WIN_REGS    = 6;

   // signed convolution sum: gaussian peaks at 4080, sobel spans +-1020
   localparam int SUM_W = 14;

   // x / 9 == (x * 3641) >> 15 for every x up to 9 * 255
   localparam int MEAN_W = 12;
   localparam logic [MEAN_W-1:0] MEAN_RECIP = 12'd3641;
   localparam int MEAN_SHIFT  = 15;
   localparam int GAUSS_SHIFT = 4;
   localparam int PIX_MAX     = 255;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int MIN_WIDTH      = 3;
   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET = 11'd1024;

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KERNEL_MODE = 1'b0,
      CSR_FRAME_WIDTH = 1'b1
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      KERNEL_IDENTITY = 3'd0,
      KERNEL_MEAN     = 3'd1,
      KERNEL_GAUSS    = 3'd2,
      KERNEL_SOBEL_H  = 3'd3,
      KERNEL_SOBEL_V  = 3'd4
   } kernel_mode_type;

   // window is row-major: win[row*3 + col]
   typedef struct packed {
      logic [WIN_TAPS-1:0][PIX_W-1:0] win;
      logic [COORD_W-1:0]             row;
      logic [COORD_W-1:0]             col;
   } window_item_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } result_item_type;

   // unused codes behave as identity
   function automatic kernel_mode_type decode_mode(input logic [MODE_W-1:0] code);
      kernel_mode_type mode;
      unique case (code)
         KERNEL_MEAN:    mode = KERNEL_MEAN;
         KERNEL_GAUSS:   mode = KERNEL_GAUSS;
         KERNEL_SOBEL_H: mode = KERNEL_SOBEL_H;
         KERNEL_SOBEL_V: mode = KERNEL_SOBEL_V;
         default:        mode = KERNEL_IDENTITY;
      endcase
      return mode;
   endfunction

endpackage

// ===== hdl/c3f_queue.sv =====
// ----------------------------------------------------------------------------
// c3f_queue
// Small register queue with occupancy count; head is shown while not empty.
// ----------------------------------------------------------------------------
`include "conv3x3_kernel_select_filter_macros.svh"

module c3f_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             head_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
      return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[rd_ptr_ff];
   assign empty     = (count_ff == '0);
   assign count     = count_ff;

   `C3F_ASSERT(a_no_overflow, !(push && !pop && count_ff == CNT_W'(DEPTH)))
   `C3F_ASSERT(a_no_underflow, !(pop && count_ff == '0))
   `C3F_ASSERT_ALWAYS(a_reset_clears, reset |=> (count_ff == '0 && wr_ptr_ff == rd_ptr_ff))

endmodule

// ===== hdl/c3f_front.sv =====
// ----------------------------------------------------------------------------
// c3f_front
// Pixel intake: raster position, two line buffers in one memory, the sliding
// 3x3 window and the choice of which items carry a result.
// ----------------------------------------------------------------------------
`include "conv3x3_kernel_select_filter_macros.svh"

module c3f_front #(
   parameter int MAX_WIDTH  = c3f_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = c3f_pkg::MAX_HEIGHT_DEF,
   parameter int MID_DEPTH  = c3f_pkg::MID_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [c3f_pkg::FW_W-1:0]             frame_width,
   input  logic                                 push,
   output logic                                 full,
   input  logic [c3f_pkg::PIX_W-1:0]            pixel_in,
   input  logic                                 frame_start,
   input  logic [$clog2(MID_DEPTH+1)-1:0]       mid_count,
   output logic                                 mid_push,
   output c3f_pkg::window_item_type             mid_item
);

   import c3f_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int EW    = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
   localparam int MCW   = $clog2(MID_DEPTH + 1);
   localparam int WORD_W = 2 * PIX_W;

   logic              accept;
   logic [EW-1:0]     eff_width;
   logic [EW-1:0]     col_next;
   logic              row_end;
   logic [CW-1:0]     cur_col;
   logic [RW-1:0]     cur_row;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;

   // line store word: {row r-2, row r-1} at one column
   logic [WORD_W-1:0] line_ram_ff [MAX_WIDTH];
   logic [WORD_W-1:0] rd_word_ff;
   logic [WORD_W-1:0] fwd_word_ff;
   logic              s1_bypass_ff;
   logic              s1_valid_ff;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic [CW-1:0]     s1_col_ff;
   logic [RW-1:0]     s1_row_ff;
   logic [PIX_W-1:0]  win_ff [WIN_REGS];

   logic [WORD_W-1:0] line_word;
   logic [PIX_W-1:0]  top_pix;
   logic [PIX_W-1:0]  mid_pix;
   logic [WORD_W-1:0] new_word;

   // room for the item in flight plus the new one
   assign full = s1_valid_ff ? (mid_count >= MCW'(MID_DEPTH - 1))
                             : (mid_count >= MCW'(MID_DEPTH));
   assign accept = push && !full;

   always_comb begin
      if (frame_width < FW_W'(MIN_WIDTH)) begin
         eff_width = EW'(MIN_WIDTH);
      end else if (EW'(frame_width) > EW'(MAX_WIDTH)) begin
         eff_width = EW'(MAX_WIDTH);
      end else begin
         eff_width = EW'(frame_width);
      end
   end

   assign cur_col  = frame_start ? '0 : col_ff;
   assign cur_row  = frame_start ? '0 : row_ff;
   assign col_next = EW'(cur_col) + EW'(1);
   assign row_end  = (col_next >= eff_width);

   always_comb begin
      col_in = row_end ? '0 : CW'(col_next);
      row_in = cur_row;
      if (row_end && cur_row != RW'(MAX_HEIGHT - 1)) begin
         row_in = cur_row + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // back-to-back items at one column: the write of the first lands on the read of the next
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff    <= pixel_in;
         s1_col_ff    <= cur_col;
         s1_row_ff    <= cur_row;
         s1_bypass_ff <= s1_valid_ff && (s1_col_ff == cur_col);
         fwd_word_ff  <= new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_word_ff <= line_ram_ff[cur_col];
      end
      if (s1_valid_ff) begin
         line_ram_ff[s1_col_ff] <= new_word;
      end
   end

   assign line_word = s1_bypass_ff ? fwd_word_ff : rd_word_ff;
   assign top_pix   = line_word[WORD_W-1:PIX_W];
   assign mid_pix   = line_word[PIX_W-1:0];
   assign new_word  = {mid_pix, s1_pix_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_REGS; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_pix;
         win_ff[4] <= mid_pix;
         win_ff[5] <= s1_pix_ff;
      end
   end

   always_comb begin
      mid_item.win[0] = win_ff[0];
      mid_item.win[1] = win_ff[3];
      mid_item.win[2] = top_pix;
      mid_item.win[3] = win_ff[1];
      mid_item.win[4] = win_ff[4];
      mid_item.win[5] = mid_pix;
      mid_item.win[6] = win_ff[2];
      mid_item.win[7] = win_ff[5];
      mid_item.win[8] = s1_pix_ff;
      mid_item.row    = COORD_W'(s1_row_ff - RW'(2));
      mid_item.col    = COORD_W'(s1_col_ff - CW'(2));
   end

   // window fully inside the frame
   assign mid_push = s1_valid_ff && (s1_row_ff >= RW'(2)) && (s1_col_ff >= CW'(2));

   `C3F_ASSERT(a_col_in_range, EW'(col_ff) < EW'(MAX_WIDTH))
   `C3F_ASSERT(a_row_saturates, row_ff <= RW'(MAX_HEIGHT - 1))
   `C3F_ASSERT(a_same_col_needs_restart,
      (accept && s1_valid_ff && s1_col_ff == cur_col) |-> frame_start)

endmodule

// ===== hdl/c3f_back.sv =====
// ----------------------------------------------------------------------------
// c3f_back
// Kernel arithmetic: weighted window sum, then divide, truncate and clamp.
// ----------------------------------------------------------------------------
module c3f_back #(
   parameter int OUT_DEPTH = c3f_pkg::OUT_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  c3f_pkg::kernel_mode_type             kernel_mode,
   input  c3f_pkg::window_item_type             mid_item,
   input  logic                                 mid_empty,
   output logic                                 mid_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]       out_count,
   output logic                                 out_push,
   output c3f_pkg::result_item_type             out_item
);

   import c3f_pkg::*;

   localparam int OCW = $clog2(OUT_DEPTH + 1);

   logic signed [SUM_W-1:0] tap [WIN_TAPS];
   logic signed [SUM_W-1:0] sum;
   logic [OCW:0]            out_load;

   logic                    a_valid_ff;
   logic signed [SUM_W-1:0] a_sum_ff;
   kernel_mode_type         a_mode_ff;
   logic [COORD_W-1:0]      a_row_ff;
   logic [COORD_W-1:0]      a_col_ff;

   logic [SUM_W-2:0]        mag;
   logic [2*MEAN_W-1:0]     mean_prod;
   logic [SUM_W-2:0]        quot;

   // output queue must hold whatever is already in flight
   assign out_load = {1'b0, out_count} + {{OCW{1'b0}}, a_valid_ff};
   assign mid_pop  = !mid_empty && (out_load < (OCW + 1)'(OUT_DEPTH));

   always_comb begin
      for (int i = 0; i < WIN_TAPS; i++) begin
         tap[i] = signed'({{(SUM_W - PIX_W){1'b0}}, mid_item.win[i]});
      end
      unique case (kernel_mode)
         KERNEL_MEAN: begin
            sum = tap[0] + tap[1] + tap[2] + tap[3] + tap[4]
                + tap[5] + tap[6] + tap[7] + tap[8];
         end
         KERNEL_GAUSS: begin
            sum = (tap[0] + tap[2] + tap[6] + tap[8])
                + ((tap[1] + tap[3] + tap[5] + tap[7]) <<< 1)
                + (tap[4] <<< 2);
         end
         KERNEL_SOBEL_H: begin
            sum = (tap[0] + (tap[1] <<< 1) + tap[2]) - (tap[6] + (tap[7] <<< 1) + tap[8]);
         end
         KERNEL_SOBEL_V: begin
            sum = (tap[0] + (tap[3] <<< 1) + tap[6]) - (tap[2] + (tap[5] <<< 1) + tap[8]);
         end
         default: begin
            sum = tap[4];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= mid_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         a_sum_ff  <= sum;
         a_mode_ff <= kernel_mode;
         a_row_ff  <= mid_item.row;
         a_col_ff  <= mid_item.col;
      end
   end

   // only positive sums are divided, so truncation toward zero is a plain floor
   always_comb begin
      mag       = a_sum_ff[SUM_W-2:0];
      mean_prod = mag[MEAN_W-1:0] * MEAN_RECIP;
      unique case (a_mode_ff)
         KERNEL_MEAN:  quot = (SUM_W - 1)'(mean_prod >> MEAN_SHIFT);
         KERNEL_GAUSS: quot = mag >> GAUSS_SHIFT;
         default:      quot = mag;
      endcase
      if (a_sum_ff[SUM_W-1] || a_sum_ff == '0) begin
         out_item.pixel = '0;
      end else if (quot > (SUM_W - 1)'(PIX_MAX)) begin
         out_item.pixel = PIX_W'(PIX_MAX);
      end else begin
         out_item.pixel = quot[PIX_W-1:0];
      end
      out_item.row = a_row_ff;
      out_item.col = a_col_ff;
   end

   assign out_push = a_valid_ff;

endmodule

// ===== hdl/conv3x3_kernel_select_filter.sv =====
// ----------------------------------------------------------------------------
// conv3x3_kernel_select_filter
// Streaming 3x3 convolution of 8-bit grayscale pixels in raster order. One
// pixel is taken per clock, sustained, for as long as results are drained at
// the same pace; the line store has one read and one write port and each
// pixel uses each once, which sets that figure. A result passes through the
// middle queue and the arithmetic register before the result queue. Every
// input pixel at row >= 2 and column >= 2 gives one result covering rows r-2..r
// and columns c-2..c, with out_row/out_col naming the window's top-left
// corner: identity, mean (/9), gaussian (/16) or horizontal/vertical sobel,
// truncated toward zero and clamped to 0..255. kernel_mode and frame_width
// are to be written only while no item is in flight. frame_start restarts
// counting at row 0, column 0; rows beyond MAX_HEIGHT-1 keep that row number.
// The line store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module conv3x3_kernel_select_filter #(
   parameter int MAX_WIDTH  = c3f_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = c3f_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_we,
   input  logic [c3f_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [c3f_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // pixel items in
   input  logic                                 push,
   output logic                                 full,
   input  logic [c3f_pkg::PIX_W-1:0]            req_pixel_in,
   input  logic                                 req_frame_start,
   // result items out
   output logic                                 empty,
   input  logic                                 pop,
   output logic [c3f_pkg::PIX_W-1:0]            rsp_pixel_out,
   output logic [c3f_pkg::COORD_W-1:0]          rsp_out_row,
   output logic [c3f_pkg::COORD_W-1:0]          rsp_out_col
);

   import c3f_pkg::*;

   localparam int MID_W = $bits(window_item_type);
   localparam int OUT_W = $bits(result_item_type);

   kernel_mode_type               kernel_mode_ff;
   logic [FW_W-1:0]               frame_width_ff;

   logic                          mid_push;
   window_item_type               mid_in_item;
   window_item_type               mid_head;
   logic                          mid_empty;
   logic                          mid_pop;
   logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

   logic                          out_push;
   result_item_type               out_in_item;
   result_item_type               out_head;
   logic                          out_empty;
   logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_mode_ff <= KERNEL_IDENTITY;
         frame_width_ff <= FRAME_WIDTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_KERNEL_MODE: kernel_mode_ff <= decode_mode(csr_wdata[MODE_W-1:0]);
            CSR_FRAME_WIDTH: frame_width_ff <= csr_wdata[FW_W-1:0];
         endcase
      end
   end

   c3f_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MID_DEPTH  (MID_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .frame_width (frame_width_ff),
      .push        (push),
      .full        (full),
      .pixel_in    (req_pixel_in),
      .frame_start (req_frame_start),
      .mid_count   (mid_count),
      .mid_push    (mid_push),
      .mid_item    (mid_in_item)
   );

   c3f_queue #(
      .WIDTH (MID_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in_item),
      .pop       (mid_pop),
      .head_data (mid_head),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   c3f_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .kernel_mode (kernel_mode_ff),
      .mid_item    (mid_head),
      .mid_empty   (mid_empty),
      .mid_pop     (mid_pop),
      .out_count   (out_count),
      .out_push    (out_push),
      .out_item    (out_in_item)
   );

   c3f_queue #(
      .WIDTH (OUT_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_in_item),
      .pop       (pop && !out_empty),
      .head_data (out_head),
      .empty     (out_empty),
      .count     (out_count)
   );

   assign empty         = out_empty;
   assign rsp_pixel_out = out_head.pixel;
   assign rsp_out_row   = out_head.row;
   assign rsp_out_col   = out_head.col;

endmodule
